// ===== hw/rtl/brss_pkg.sv =====
// Shared constants and command codes for the block-decomposed range root and sum table.
package brss_pkg;
	localparam int TABLE_DEPTH   = 1024;
	localparam int BLK_LEN       = 32;
	localparam int VALUE_WIDTH   = 32;
	localparam int IDX_W         = $clog2(TABLE_DEPTH);
	localparam int OFF_W         = $clog2(BLK_LEN);
	localparam int BLOCK_COUNT   = (TABLE_DEPTH + BLK_LEN - 1) / BLK_LEN;
	localparam int BLK_W         = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
	localparam int BSUM_W        = VALUE_WIDTH + OFF_W;
	localparam int SUM_W         = 42;
	localparam int ENTRY_COUNT_W = 11;
	localparam int CMD_W         = 2;
	localparam int SQ_TOP        = VALUE_WIDTH - 2 + (VALUE_WIDTH % 2);
	localparam logic [ENTRY_COUNT_W-1:0] ENTRY_COUNT_RESET = 11'd1024;

	localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ROOT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SUM  = 2'd2;
endpackage

// ===== hw/rtl/brss_if.sv =====
// Channel interfaces for command words, result words and the configuration write.
interface brss_req_if;
	import brss_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [CMD_W-1:0]       cmd;
	logic [IDX_W-1:0]       first_index;
	logic [IDX_W-1:0]       last_index;
	logic [VALUE_WIDTH-1:0] load_value;
	modport source (output valid, output cmd, output first_index, output last_index,
		output load_value, input ready);
	modport sink (input valid, input cmd, input first_index, input last_index,
		input load_value, output ready);
endinterface

interface brss_rsp_if;
	import brss_pkg::*;
	logic             valid;
	logic             ready;
	logic [SUM_W-1:0] range_sum;
	logic             status;
	modport source (output valid, output range_sum, output status, input ready);
	modport sink (input valid, input range_sum, input status, output ready);
endinterface

interface brss_cfg_if;
	import brss_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [ENTRY_COUNT_W-1:0] entry_count;
	modport source (output valid, output entry_count, input ready);
	modport sink (input valid, input entry_count, output ready);
endinterface

// ===== hw/rtl/brss_ram.sv =====
// Generic single-port RAM with registered read.
module brss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// ===== hw/rtl/block_decomposed_range_sqrt_sum_top.sv =====
// Top level of the block-decomposed table with range square root and range sum.
//
// Channels: req carries one command word (load, range root, range sum), rsp
// returns one result word per command, cfg writes entry_count at any time
// (cfg.ready is always high; write it only while the block is idle).
// A rejected command (bad index, reversed range, unused code) returns
// status 1 with a zero sum and changes nothing.
// Each command, from accept to result valid in the output register:
//   load: the old entry is read, then the table entry and block sum are written.
//   range sum: each loose entry is read and added, each full block adds its block sum.
//   range root: each entry is read, and each entry above 1 runs the root iterations
//   and is written back, all through the one shared root step unit and the
//   single table RAM port.
// req.ready is high only while no command is in work, so one command runs
// at a time. After reset the table RAM is cleared one entry per cycle,
// all TABLE_DEPTH (1024) entries, with req.ready low; block sums clear at once.
// A result waits in the output register while rsp.ready is low; a new
// command is taken meanwhile and its own result holds until the slot frees.
module block_decomposed_range_sqrt_sum_top (
	input  logic clk,
	input  logic arst_n,
	brss_req_if.sink   req,
	brss_rsp_if.source rsp,
	brss_cfg_if.sink   cfg
);
	import brss_pkg::*;

	localparam logic [3:0] S_CLEAR   = 4'd0;
	localparam logic [3:0] S_IDLE    = 4'd1;
	localparam logic [3:0] S_LD_WAIT = 4'd2;
	localparam logic [3:0] S_LD_UPD  = 4'd3;
	localparam logic [3:0] S_SUM_CHK = 4'd4;
	localparam logic [3:0] S_SUM_ACC = 4'd5;
	localparam logic [3:0] S_RT_CHK  = 4'd6;
	localparam logic [3:0] S_RT_LD   = 4'd7;
	localparam logic [3:0] S_RT_IT   = 4'd8;
	localparam logic [3:0] S_RT_WR   = 4'd9;
	localparam logic [3:0] S_FIN     = 4'd10;

	logic [3:0]               state_q;
	logic [IDX_W-1:0]         idx_q;
	logic [ENTRY_COUNT_W-1:0] entry_count_q;
	logic [BSUM_W-1:0]        bsum_q [BLOCK_COUNT];
	logic                     rsp_vld_q;
	logic [SUM_W-1:0]         rsp_sum_q;
	logic                     rsp_st_q;

	logic [IDX_W-1:0]         hi_q;
	logic [VALUE_WIDTH-1:0]   val_q;
	logic [SUM_W-1:0]         sum_q;
	logic                     err_q;
	logic [VALUE_WIDTH-1:0]   rem_q;
	logic [VALUE_WIDTH-1:0]   res_q;
	logic [VALUE_WIDTH-1:0]   bit_q;

	logic                     ram_we;
	logic [VALUE_WIDTH-1:0]   ram_wdata;
	logic [VALUE_WIDTH-1:0]   ram_rdata;

	logic [31:0]              usable;
	logic                     cmd_ok;
	logic                     req_fire;
	logic                     rsp_load;
	logic [IDX_W:0]           blk_end;
	logic                     blk_full;
	logic [BLK_W-1:0]         blk;
	logic [VALUE_WIDTH:0]     trial;
	logic                     take;
	logic                     bsum_we;
	logic [VALUE_WIDTH-1:0]   bsum_old;
	logic [VALUE_WIDTH-1:0]   bsum_new;

	brss_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(TABLE_DEPTH)) u_table (
		.clk   (clk),
		.we    (ram_we),
		.addr  (idx_q),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == S_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign rsp.valid     = rsp_vld_q;
	assign rsp.range_sum = rsp_sum_q;
	assign rsp.status    = rsp_st_q;
	assign rsp_load  = (state_q == S_FIN) && (!rsp_vld_q || rsp.ready);

	always_comb begin
		usable = (32'(entry_count_q) > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : 32'(entry_count_q);
		unique case (req.cmd)
			CMD_LOAD: cmd_ok = 32'(req.first_index) < usable;
			CMD_ROOT, CMD_SUM: cmd_ok = (req.first_index <= req.last_index) &&
				(32'(req.last_index) < usable);
			default: cmd_ok = 1'b0;
		endcase
	end

	assign blk_end  = {1'b0, idx_q} + (IDX_W + 1)'(BLK_LEN - 1);
	assign blk_full = (idx_q[OFF_W-1:0] == '0) && (blk_end <= {1'b0, hi_q});
	assign blk      = BLK_W'(idx_q >> OFF_W);
	assign trial    = {1'b0, res_q} + {1'b0, bit_q};
	assign take     = {1'b0, rem_q} >= trial;

	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = '0;
		bsum_we   = 1'b0;
		bsum_old  = ram_rdata;
		bsum_new  = val_q;
		unique case (state_q)
			S_CLEAR: ram_we = 1'b1;
			S_LD_UPD: begin
				ram_we    = 1'b1;
				ram_wdata = val_q;
				bsum_we   = 1'b1;
			end
			S_RT_WR: begin
				ram_we    = 1'b1;
				ram_wdata = res_q;
				bsum_we   = 1'b1;
				bsum_old  = val_q;
				bsum_new  = res_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			idx_q         <= '0;
			entry_count_q <= ENTRY_COUNT_RESET;
			rsp_vld_q     <= 1'b0;
			for (int b = 0; b < BLOCK_COUNT; b++) begin
				bsum_q[b] <= '0;
			end
		end else begin
			if (cfg.valid) begin
				entry_count_q <= cfg.entry_count;
			end
			if (bsum_we) begin
				bsum_q[blk] <= bsum_q[blk] - BSUM_W'(bsum_old) + BSUM_W'(bsum_new);
			end
			if (rsp_load) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					if (idx_q == IDX_W'(TABLE_DEPTH - 1)) begin
						idx_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (req_fire) begin
						idx_q <= req.first_index;
						if (!cmd_ok) begin
							state_q <= S_FIN;
						end else begin
							unique case (req.cmd)
								CMD_LOAD: state_q <= S_LD_WAIT;
								CMD_ROOT: state_q <= S_RT_CHK;
								default:  state_q <= S_SUM_CHK;
							endcase
						end
					end
				end
				S_LD_WAIT: state_q <= S_LD_UPD;
				S_LD_UPD:  state_q <= S_FIN;
				S_SUM_CHK: begin
					if (blk_full) begin
						if (blk_end == {1'b0, hi_q}) begin
							state_q <= S_FIN;
						end else begin
							idx_q <= idx_q + IDX_W'(BLK_LEN);
						end
					end else begin
						state_q <= S_SUM_ACC;
					end
				end
				S_SUM_ACC: begin
					if (idx_q == hi_q) begin
						state_q <= S_FIN;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_SUM_CHK;
					end
				end
				S_RT_CHK: state_q <= S_RT_LD;
				S_RT_LD: begin
					if (ram_rdata > VALUE_WIDTH'(1)) begin
						state_q <= S_RT_IT;
					end else if (idx_q == hi_q) begin
						state_q <= S_FIN;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_RT_CHK;
					end
				end
				S_RT_IT: begin
					if (bit_q[0]) begin
						state_q <= S_RT_WR;
					end
				end
				S_RT_WR: begin
					if (idx_q == hi_q) begin
						state_q <= S_FIN;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_RT_CHK;
					end
				end
				S_FIN: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			hi_q  <= req.last_index;
			val_q <= req.load_value;
			sum_q <= '0;
			err_q <= !cmd_ok;
		end
		if (state_q == S_SUM_CHK && blk_full) begin
			sum_q <= sum_q + SUM_W'(bsum_q[blk]);
		end
		if (state_q == S_SUM_ACC) begin
			sum_q <= sum_q + SUM_W'(ram_rdata);
		end
		if (state_q == S_RT_LD) begin
			val_q <= ram_rdata;
			rem_q <= ram_rdata;
			res_q <= '0;
			bit_q <= VALUE_WIDTH'(1) << SQ_TOP;
		end
		if (state_q == S_RT_IT) begin
			if (take) begin
				rem_q <= rem_q - trial[VALUE_WIDTH-1:0];
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (rsp_load) begin
			rsp_sum_q <= err_q ? '0 : sum_q;
			rsp_st_q  <= err_q;
		end
	end

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status |-> rsp.range_sum == '0)
		else $error("rejected command returned a nonzero sum");

	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> !req.ready)
		else $error("command taken during table clear");

	a_idle_nowrite: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE || state_q == S_FIN |-> !ram_we && !bsum_we)
		else $error("table written outside a command");

	a_root_steps: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RT_WR |-> $past(state_q) == S_RT_IT)
		else $error("root written before its iterations ended");
endmodule
